// File: hw/rtl/mpfc_pkg.sv
// ----------------------------------------------------------------------------
// mpfc_pkg
// Shared widths, codes and controller/datapath handshake types for the
// reciprocal frequency counter.
// ----------------------------------------------------------------------------
package mpfc_pkg;

   localparam int TIME_BITS     = 32;
   localparam int COUNT_BITS    = 10;
   localparam int FRACTION_BITS = 8;
   localparam int FREQ_BITS     = 38;
   localparam int OP_BITS       = 2;
   localparam int MODE_BITS     = 2;

   // microseconds per second, as a multiplier constant
   localparam int US_BITS = 20;
   localparam logic [US_BITS-1:0] US_PER_S = US_BITS'(1000000);

   // edge count with room for the wrapped case of 2^COUNT_BITS
   localparam int N_BITS    = COUNT_BITS + 1;
   localparam int PROD_BITS = N_BITS + US_BITS;
   localparam int DIV_STEPS = FREQ_BITS;
   localparam int STEP_BITS = $clog2(DIV_STEPS);

   localparam logic [COUNT_BITS-1:0] EDGE_COUNT_RESET = COUNT_BITS'(10);

   typedef logic [OP_BITS-1:0]    op_type;
   typedef logic [MODE_BITS-1:0]  mode_type;
   typedef logic [TIME_BITS-1:0]  time_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [FREQ_BITS-1:0]  freq_type;

   localparam op_type OP_ARM   = 2'd0;
   localparam op_type OP_EDGE  = 2'd1;
   localparam op_type OP_QUERY = 2'd2;

   localparam mode_type MODE_IDLE     = 2'd0;
   localparam mode_type MODE_LAUNCH   = 2'd1;
   localparam mode_type MODE_COUNTING = 2'd2;
   localparam mode_type MODE_DONE     = 2'd3;

   typedef struct packed {
      logic accept;  // take the request word, update measurement state
      logic prep;    // load dividend or clear the quotient
      logic step;    // one restoring divide step
      logic load;    // move result into the output register
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
      logic out_busy;
   } status_type;

endpackage

// File: hw/rtl/mpfc_req_if.sv
// ----------------------------------------------------------------------------
// mpfc_req_if
// Request channel: operation code and event timestamp.
// ----------------------------------------------------------------------------
interface mpfc_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   operation;
   logic [31:0]                  timestamp_us;

   modport source (output valid, output operation, output timestamp_us, input ready);
   modport sink   (input valid, input operation, input timestamp_us, output ready);
endinterface

// File: hw/rtl/mpfc_rsp_if.sv
// ----------------------------------------------------------------------------
// mpfc_rsp_if
// Response channel: state, done flag, period and frequency.
// ----------------------------------------------------------------------------
interface mpfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic        done_res;
   logic [31:0] period_us;
   logic [37:0] frequency_q8;

   modport source (output valid, output mode, output done_res, output period_us,
                   output frequency_q8, input ready);
   modport sink   (input valid, input mode, input done_res, input period_us,
                   input frequency_q8, output ready);
endinterface

// File: hw/rtl/mpfc_ctrl.sv
// ----------------------------------------------------------------------------
// mpfc_ctrl
// Sequencer: accept a request word, prepare, run the divider when a division
// is needed, hand the result to the output register.
// ----------------------------------------------------------------------------
module mpfc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mpfc_pkg::status_type status,
   output mpfc_pkg::cmd_type    cmd
);
   import mpfc_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PREP = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_LOAD = 2'd3;

   logic [1:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = status.need_div ? S_DIV : S_LOAD;
         end
         S_DIV: begin
            cmd.step = 1'b1;
            if (status.div_last) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (!status.out_busy) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/mpfc_datapath.sv
// ----------------------------------------------------------------------------
// mpfc_datapath
// Measurement state, edge_count register, numerator multiply, restoring
// divider and the output register.
// ----------------------------------------------------------------------------
module mpfc_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  mpfc_pkg::count_type   csr_wdata,
   input  mpfc_pkg::op_type      req_operation,
   input  mpfc_pkg::time_type    req_timestamp_us,
   input  mpfc_pkg::cmd_type     cmd,
   output mpfc_pkg::status_type  status,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output mpfc_pkg::mode_type    rsp_mode,
   output logic                  rsp_done_res,
   output mpfc_pkg::time_type    rsp_period_us,
   output mpfc_pkg::freq_type    rsp_frequency_q8
);
   import mpfc_pkg::*;

   count_type edge_count_ff;
   mode_type  mode_ff, mode_in;
   time_type  start_ff, start_in;
   time_type  period_ff, period_in;
   count_type seen_ff, seen_in;

   logic [TIME_BITS:0]   rem_ff;
   freq_type             quo_ff;
   logic [STEP_BITS-1:0] step_ff;

   logic                 out_valid_ff;
   mode_type             out_mode_ff;
   time_type             out_period_ff;
   freq_type             out_freq_ff;

   logic [N_BITS-1:0]    n_val;
   logic [PROD_BITS-1:0] product;
   freq_type             numerator;
   logic [TIME_BITS:0]   rem_shift;
   logic                 fits;
   count_type            seen_inc;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff <= EDGE_COUNT_RESET;
      end else if (csr_we) begin
         edge_count_ff <= csr_wdata;
      end
   end

   // measurement state update
   always_comb begin
      mode_in   = mode_ff;
      start_in  = start_ff;
      period_in = period_ff;
      seen_in   = seen_ff;
      seen_inc  = seen_ff + 1'b1;
      case (req_operation)
         OP_ARM: begin
            mode_in   = MODE_LAUNCH;
            period_in = '0;
            seen_in   = '0;
         end
         OP_EDGE: begin
            if (mode_ff == MODE_COUNTING) begin
               seen_in = seen_inc;
               if (seen_inc == edge_count_ff) begin
                  period_in = req_timestamp_us - start_ff;
                  mode_in   = MODE_DONE;
               end
            end else if (mode_ff == MODE_LAUNCH) begin
               start_in = req_timestamp_us;
               mode_in  = MODE_COUNTING;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         start_ff  <= '0;
         period_ff <= '0;
         seen_ff   <= '0;
      end else if (cmd.accept) begin
         mode_ff   <= mode_in;
         start_ff  <= start_in;
         period_ff <= period_in;
         seen_ff   <= seen_in;
      end
   end

   // numerator n * 1e6 * 2^fraction, n = 2^count_bits when edge_count is zero
   always_comb begin
      n_val     = (edge_count_ff == '0) ? N_BITS'(1) << COUNT_BITS
                                        : {1'b0, edge_count_ff};
      product   = PROD_BITS'(n_val) * PROD_BITS'(US_PER_S);
      numerator = FREQ_BITS'({product, {FRACTION_BITS{1'b0}}});
   end

   // restoring divide, dividend shifted out of the top of the quotient
   always_comb begin
      rem_shift = {rem_ff[TIME_BITS-1:0], quo_ff[FREQ_BITS-1]};
      fits      = rem_shift >= {1'b0, period_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         rem_ff  <= '0;
         step_ff <= '0;
         quo_ff  <= status.need_div ? numerator : '0;
      end else if (cmd.step) begin
         rem_ff  <= fits ? rem_shift - {1'b0, period_ff} : rem_shift;
         quo_ff  <= {quo_ff[FREQ_BITS-2:0], fits};
         step_ff <= step_ff + 1'b1;
      end
   end

   assign status.need_div = (mode_ff == MODE_DONE) && (period_ff != '0);
   assign status.div_last = (step_ff == STEP_BITS'(DIV_STEPS - 1));
   assign status.out_busy = out_valid_ff && !rsp_ready;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_mode_ff   <= mode_ff;
         out_period_ff <= period_ff;
         out_freq_ff   <= quo_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_mode         = out_mode_ff;
   assign rsp_done_res     = (out_mode_ff == MODE_DONE);
   assign rsp_period_us    = out_period_ff;
   assign rsp_frequency_q8 = out_freq_ff;

endmodule

// File: hw/rtl/multi_period_frequency_counter_unit.sv
// ----------------------------------------------------------------------------
// multi_period_frequency_counter_unit
// Reciprocal frequency counter: arm, timestamp edges, report period
// and frequency in Q8 Hz.
// ----------------------------------------------------------------------------
// Each request word yields one response word. A word that leaves the counter
// in done with a nonzero period passes through accept, prepare, 38 steps of
// the restoring divider and load; any other word skips the divider, which
// is 38 bits wide and makes one quotient bit per cycle. A new request is
// taken once the previous one has reached the output register, so the
// response may wait on rsp_chan.ready while the next request is already
// being worked on. The user must write edge_count via csr_we only while no
// request is in flight (the block does not check); a zero edge_count stands for 1024 (2^COUNT_BITS).
module multi_period_frequency_counter_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  mpfc_pkg::count_type csr_wdata,
   mpfc_req_if.sink            req_chan,
   mpfc_rsp_if.source          rsp_chan
);
   import mpfc_pkg::*;

   cmd_type    cmd;
   status_type status;

   mpfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mpfc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_operation    (req_chan.operation),
      .req_timestamp_us (req_chan.timestamp_us),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_mode         (rsp_chan.mode),
      .rsp_done_res     (rsp_chan.done_res),
      .rsp_period_us    (rsp_chan.period_us),
      .rsp_frequency_q8 (rsp_chan.frequency_q8)
   );

endmodule

// File: hw/rtl/mpfc_checker.sv
// ----------------------------------------------------------------------------
// mpfc_checker
// Port-level checks on the frequency counter, bound to the top level.
// ----------------------------------------------------------------------------
module mpfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_mode,
   input logic        rsp_done_res,
   input logic [31:0] rsp_period_us,
   input logic [37:0] rsp_frequency_q8
);
   import mpfc_pkg::*;

   // one request in work at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frequency_q8))
      else $error("response word dropped or changed while stalled");

   a_done_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_done_res == (rsp_mode == MODE_DONE))
      else $error("done flag disagrees with mode");

   // nothing measured unless done
   a_not_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode != MODE_DONE |-> rsp_period_us == '0 && rsp_frequency_q8 == '0)
      else $error("period or frequency nonzero before done");

   a_zero_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_period_us == '0 |-> rsp_frequency_q8 == '0)
      else $error("frequency nonzero with zero period");

endmodule

bind multi_period_frequency_counter_unit mpfc_checker u_mpfc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_mode         (rsp_chan.mode),
   .rsp_done_res     (rsp_chan.done_res),
   .rsp_period_us    (rsp_chan.period_us),
   .rsp_frequency_q8 (rsp_chan.frequency_q8)
);
